// ===== hdl/fpad_pkg.sv =====
// shared types and constants for the fresnel phase azimuth derivative pipeline
package fpad_pkg;

    localparam logic [31:0] WAVENUMBER_RESET = 32'd65536;

    localparam int SQ_W       = 66;
    localparam int ROOT_W     = 49;
    localparam int SQRT_STEPS = 49;
    localparam int SQ_PAIRS   = SQ_W / 2;
    localparam int SREM_W     = 52;
    localparam int NUM_W      = 66;
    localparam int Q_W        = 50;
    localparam int DIV_STEPS  = Q_W;
    localparam int DREM_W     = 50;
    localparam int NUM_LOW    = NUM_W - (DREM_W - 2);

    typedef struct packed {
        logic signed [31:0] observer_x;
        logic signed [31:0] observer_y;
        logic signed [31:0] observer_z;
        logic signed [31:0] intercept_x;
        logic signed [31:0] intercept_y;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
    } t_in;

    typedef struct packed {
        logic signed [63:0] phase_slope;
        logic               zero_distance;
        logic               overflow;
    } t_out;

    typedef struct packed {
        logic              vld;
        logic              zero;
        logic [SQ_W-1:0]   s1;
        logic [SQ_W-1:0]   s2;
        logic [SREM_W-1:0] rem1;
        logic [SREM_W-1:0] rem2;
        logic [ROOT_W-1:0] root1;
        logic [ROOT_W-1:0] root2;
        logic [NUM_W-1:0]  m1;
        logic [NUM_W-1:0]  m2;
        logic              neg1;
        logic              neg2;
    } t_sq;

    typedef struct packed {
        logic              vld;
        logic              zero;
        logic [ROOT_W-1:0] d1;
        logic [ROOT_W-1:0] d2;
        logic [DREM_W-1:0] rem1;
        logic [DREM_W-1:0] rem2;
        logic [Q_W-1:0]    q1;
        logic [Q_W-1:0]    q2;
        logic [NUM_W-1:0]  m1;
        logic [NUM_W-1:0]  m2;
        logic              neg1;
        logic              neg2;
    } t_dv;

endpackage

// ===== hdl/fresnel_phase_azimuth_derivative_top.sv =====
// fresnel phase azimuth derivative: fully pipelined top level
//
//  channel   ports                              beat taken when
//  item in   start, busy, i_item                start high, busy low
//  result    o_result_strobe, o_result          strobe high (one cycle)
//  config    i_cfg_we, i_cfg_wdata              i_cfg_we high
//
//  one item per cycle
//  the pipeline holds the 49 square root steps and 50 quotient steps, one per stage
//  synchronous active-low reset clears valid bits and sets k to 1.0
//  busy is never raised: nothing downstream can stall the pipeline
module fresnel_phase_azimuth_derivative_top
    import fpad_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_in         i_item,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    output logic        o_result_strobe,
    output t_out        o_result
);

    logic [31:0] r_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= WAVENUMBER_RESET;
        end else if (i_cfg_we) begin
            r_k <= i_cfg_wdata;
        end
    end

    assign busy = 1'b0;

    // stage a: differences
    logic               r_va;
    logic signed [32:0] r_dx, r_dy, r_ux, r_uy;
    logic signed [31:0] r_h, r_px, r_py;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else begin
            r_va <= start & ~busy;
        end
        r_dx <= 33'(i_item.observer_x) - 33'(i_item.point_x);
        r_dy <= 33'(i_item.observer_y) - 33'(i_item.point_y);
        r_ux <= 33'(i_item.observer_x) - 33'(i_item.intercept_x);
        r_uy <= 33'(i_item.observer_y) - 33'(i_item.intercept_y);
        r_h  <= i_item.observer_z;
        r_px <= i_item.point_x;
        r_py <= i_item.point_y;
    end

    // stage b: products
    logic               r_vb;
    logic signed [65:0] r_dx2, r_dy2, r_ux2, r_uy2, r_h2;
    logic signed [64:0] r_dxpy, r_dypx, r_uypx, r_uxpy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
        end else begin
            r_vb <= r_va;
        end
        r_dx2  <= 66'(r_dx * r_dx);
        r_dy2  <= 66'(r_dy * r_dy);
        r_ux2  <= 66'(r_ux * r_ux);
        r_uy2  <= 66'(r_uy * r_uy);
        r_h2   <= 66'(r_h * r_h);
        r_dxpy <= 65'(r_dx * 33'(r_py));
        r_dypx <= 65'(r_dy * 33'(r_px));
        r_uypx <= 65'(r_uy * 33'(r_px));
        r_uxpy <= 65'(r_ux * 33'(r_py));
    end

    // stage c: squared lengths and cross products
    logic               r_vc;
    logic [SQ_W-1:0]    r_s1, r_s2;
    logic signed [65:0] r_n1, r_n2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc <= 1'b0;
        end else begin
            r_vc <= r_vb;
        end
        r_s1 <= SQ_W'(r_dx2 + r_dy2 + r_h2);
        r_s2 <= SQ_W'(r_ux2 + r_uy2 + r_h2);
        r_n1 <= 66'(r_dxpy) - 66'(r_dypx);
        r_n2 <= 66'(r_uypx) - 66'(r_uxpy);
    end

    // square root pipeline
    t_sq r_sq [0:SQRT_STEPS];
    t_sq n_sq [0:SQRT_STEPS];

    always_comb begin
        n_sq[0]       = '0;
        n_sq[0].vld   = r_vc & i_rst_n;
        n_sq[0].zero  = (r_s1 == '0) || (r_s2 == '0);
        n_sq[0].s1    = r_s1;
        n_sq[0].s2    = r_s2;
        n_sq[0].neg1  = r_n1[65];
        n_sq[0].neg2  = r_n2[65];
        n_sq[0].m1    = r_n1[65] ? NUM_W'(-r_n1) : NUM_W'(r_n1);
        n_sq[0].m2    = r_n2[65] ? NUM_W'(-r_n2) : NUM_W'(r_n2);
    end

    function automatic logic [SREM_W+ROOT_W-1:0] sqrt_step(
        input logic [SREM_W-1:0] rem,
        input logic [ROOT_W-1:0] root,
        input logic [1:0]        pair
    );
        logic [SREM_W-1:0] t_rem;
        logic [SREM_W-1:0] trial;
        t_rem = {rem[SREM_W-3:0], pair};
        trial = SREM_W'({root, 2'b01});
        if (t_rem >= trial) begin
            return {t_rem - trial, root[ROOT_W-2:0], 1'b1};
        end else begin
            return {t_rem, root[ROOT_W-2:0], 1'b0};
        end
    endfunction

    for (genvar k = 0; k <= SQRT_STEPS; k++) begin : g_sq_reg
        always_ff @(posedge i_clk) begin
            r_sq[k] <= n_sq[k];
        end
    end

    for (genvar k = 1; k <= SQRT_STEPS; k++) begin : g_sq_step
        logic [1:0] w_p1, w_p2;
        if (k - 1 < SQ_PAIRS) begin : g_pair
            assign w_p1 = r_sq[k-1].s1[SQ_W-1-2*(k-1) -: 2];
            assign w_p2 = r_sq[k-1].s2[SQ_W-1-2*(k-1) -: 2];
        end else begin : g_zero
            assign w_p1 = 2'b00;
            assign w_p2 = 2'b00;
        end
        always_comb begin
            n_sq[k] = r_sq[k-1];
            n_sq[k].vld = r_sq[k-1].vld & i_rst_n;
            {n_sq[k].rem1, n_sq[k].root1} =
                sqrt_step(r_sq[k-1].rem1, r_sq[k-1].root1, w_p1);
            {n_sq[k].rem2, n_sq[k].root2} =
                sqrt_step(r_sq[k-1].rem2, r_sq[k-1].root2, w_p2);
        end
    end

    // quotient pipeline
    t_dv r_dv [0:DIV_STEPS];
    t_dv n_dv [0:DIV_STEPS];

    always_comb begin
        n_dv[0]      = '0;
        n_dv[0].vld  = r_sq[SQRT_STEPS].vld & i_rst_n;
        n_dv[0].zero = r_sq[SQRT_STEPS].zero;
        n_dv[0].d1   = r_sq[SQRT_STEPS].root1;
        n_dv[0].d2   = r_sq[SQRT_STEPS].root2;
        n_dv[0].m1   = r_sq[SQRT_STEPS].m1;
        n_dv[0].m2   = r_sq[SQRT_STEPS].m2;
        n_dv[0].neg1 = r_sq[SQRT_STEPS].neg1;
        n_dv[0].neg2 = r_sq[SQRT_STEPS].neg2;
        n_dv[0].rem1 = DREM_W'(r_sq[SQRT_STEPS].m1[NUM_W-1:NUM_LOW]);
        n_dv[0].rem2 = DREM_W'(r_sq[SQRT_STEPS].m2[NUM_W-1:NUM_LOW]);
    end

    function automatic logic [DREM_W+Q_W-1:0] div_step(
        input logic [DREM_W-1:0] rem,
        input logic [Q_W-1:0]    q,
        input logic [ROOT_W-1:0] d,
        input logic              nb
    );
        logic [DREM_W-1:0] t_rem;
        t_rem = {rem[DREM_W-2:0], nb};
        if (t_rem >= DREM_W'(d)) begin
            return {t_rem - DREM_W'(d), q[Q_W-2:0], 1'b1};
        end else begin
            return {t_rem, q[Q_W-2:0], 1'b0};
        end
    endfunction

    for (genvar k = 0; k <= DIV_STEPS; k++) begin : g_dv_reg
        always_ff @(posedge i_clk) begin
            r_dv[k] <= n_dv[k];
        end
    end

    for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_dv_step
        logic w_b1, w_b2;
        if (k - 1 < NUM_LOW) begin : g_bit
            assign w_b1 = r_dv[k-1].m1[NUM_LOW-k];
            assign w_b2 = r_dv[k-1].m2[NUM_LOW-k];
        end else begin : g_zero
            assign w_b1 = 1'b0;
            assign w_b2 = 1'b0;
        end
        always_comb begin
            n_dv[k] = r_dv[k-1];
            n_dv[k].vld = r_dv[k-1].vld & i_rst_n;
            {n_dv[k].rem1, n_dv[k].q1} =
                div_step(r_dv[k-1].rem1, r_dv[k-1].q1, r_dv[k-1].d1, w_b1);
            {n_dv[k].rem2, n_dv[k].q2} =
                div_step(r_dv[k-1].rem2, r_dv[k-1].q2, r_dv[k-1].d2, w_b2);
        end
    end

    // final stages: sum, magnitude, scale by k, saturate
    logic               r_vf1, r_zf1;
    logic signed [51:0] r_sum;
    logic signed [50:0] w_t1, w_t2;

    assign w_t1 = r_dv[DIV_STEPS].neg1 ? -51'(r_dv[DIV_STEPS].q1) : 51'(r_dv[DIV_STEPS].q1);
    assign w_t2 = r_dv[DIV_STEPS].neg2 ? -51'(r_dv[DIV_STEPS].q2) : 51'(r_dv[DIV_STEPS].q2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vf1 <= 1'b0;
        end else begin
            r_vf1 <= r_dv[DIV_STEPS].vld;
        end
        r_zf1 <= r_dv[DIV_STEPS].zero;
        r_sum <= 52'(w_t1) + 52'(w_t2);
    end

    logic        r_vf2, r_zf2, r_neg2;
    logic [51:0] r_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vf2 <= 1'b0;
        end else begin
            r_vf2 <= r_vf1;
        end
        r_zf2  <= r_zf1;
        r_neg2 <= r_sum[51];
        r_mag  <= r_sum[51] ? 52'(-r_sum) : 52'(r_sum);
    end

    logic        r_vf3, r_zf3, r_neg3;
    logic [63:0] r_plo;
    logic [51:0] r_phi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vf3 <= 1'b0;
        end else begin
            r_vf3 <= r_vf2;
        end
        r_zf3  <= r_zf2;
        r_neg3 <= r_neg2;
        r_plo  <= 64'(r_mag[31:0]) * 64'(r_k);
        r_phi  <= 52'(r_mag[51:32]) * 52'(r_k);
    end

    logic        r_vf4, r_zf4, r_neg4;
    logic [67:0] r_psh;
    logic [83:0] w_p;

    assign w_p = {r_phi, 32'd0} + 84'(r_plo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vf4 <= 1'b0;
        end else begin
            r_vf4 <= r_vf3;
        end
        r_zf4  <= r_zf3;
        r_neg4 <= r_neg3;
        r_psh  <= w_p[83:16];
    end

    t_out w_res;

    always_comb begin
        w_res = '0;
        priority if (r_zf4) begin
            w_res.zero_distance = 1'b1;
        end else if (!r_neg4 && (r_psh[67:63] != '0)) begin
            w_res.phase_slope = 64'h7FFF_FFFF_FFFF_FFFF;
            w_res.overflow    = 1'b1;
        end else if (r_neg4 && (r_psh[67:64] != '0 || (r_psh[63] && r_psh[62:0] != '0))) begin
            w_res.phase_slope = 64'h8000_0000_0000_0000;
            w_res.overflow    = 1'b1;
        end else begin
            w_res.phase_slope = r_neg4 ? -r_psh[63:0] : r_psh[63:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_result_strobe <= 1'b0;
        end else begin
            o_result_strobe <= r_vf4;
        end
        o_result <= w_res;
    end

endmodule
